@@ src/efa_pkg.sv @@
// Shared constants, codes and types of the event flag allocator.
package efa_pkg;

	localparam int ID_COUNT   = 128;
	localparam int IDX_W      = $clog2(ID_COUNT);
	localparam int FREE_W     = $clog2(ID_COUNT + 1);
	localparam int ID_W       = 7;
	localparam int STATUS_W   = 8;
	localparam int POS_W      = 8;
	localparam int CODE_W     = 3;
	localparam int MODE_W     = 3;

	localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SET     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_GET     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_WAIT    = 3'd4;

	localparam logic [CODE_W-1:0] RES_OK           = 3'd0;
	localparam logic [CODE_W-1:0] RES_FULL         = 3'd1;
	localparam logic [CODE_W-1:0] RES_COLLISION    = 3'd2;
	localparam logic [CODE_W-1:0] RES_INVALID      = 3'd3;
	localparam logic [CODE_W-1:0] RES_WAIT_DONE    = 3'd4;
	localparam logic [CODE_W-1:0] RES_WAIT_PENDING = 3'd5;

	localparam logic signed [STATUS_W-1:0] STATUS_COMPLETE = 8'sd1;
	localparam logic [POS_W-1:0]           POS_MAX         = '1;

	typedef logic [ID_COUNT-1:0] map_t;

	typedef struct packed {
		logic                      found;
		logic [IDX_W-1:0]          index;
	} ffz_result_t;

endpackage

@@ src/efa_ffz.sv @@
// Find-first-zero priority encoder over the in-use bitmap.
module efa_ffz
	import efa_pkg::*;
(
	input  map_t        map,
	output ffz_result_t res
);

	always_comb begin
		res.found = 1'b0;
		res.index = '0;
		for (int i = ID_COUNT - 1; i >= 0; i--) begin
			if (!map[i]) begin
				res.found = 1'b1;
				res.index = IDX_W'(i);
			end
		end
	end

endmodule

@@ src/event_flag_allocator_wait_test.sv @@
// Top level of the event flag allocator with the wait-list test.
//
// The block takes one command transfer per clock while the output is not
// stalled: a transfer is captured in an input register, then one pass
// of logic reads and updates the bitmaps and loads the result register. A
// wait-list element that is not the last of its list gives no result. The
// longest path is the find-first-zero encode over the in-use bitmap plus the
// bitmap update. While a result waits on a stalled output, one more command
// can enter the input register; if that command also gives a result, the
// input holds off until the waiting result is taken. Wait-list elements that
// are not last keep passing through while the output is stalled.
module event_flag_allocator_wait_test
	import efa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // evt_id[6:0], requested_status[14:7], zero[15]
	input  logic [3:0]  s_axis_tuser,  // mode[2:0], match_any[3]
	input  logic        s_axis_tlast,  // last_in_list
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // granted_id[6:0], is_complete[7],
	                                   // pending_position[15:8], free_left[23:16]
	output logic [2:0]  m_axis_tuser   // result_code[2:0]
);

	logic                       valid_s1;
	logic [MODE_W-1:0]          mode_s1;
	logic [ID_W-1:0]            id_s1;
	logic signed [STATUS_W-1:0] status_s1;
	logic                       any_s1;
	logic                       last_s1;

	map_t               in_use_q;
	map_t               complete_q;
	logic [FREE_W-1:0]  free_q;
	logic [POS_W-1:0]   list_pos_q;
	logic               any_found_q;
	logic               miss_seen_q;
	logic [POS_W-1:0]   miss_pos_q;

	logic               out_valid_q;
	logic [CODE_W-1:0]  code_q;
	logic [ID_W-1:0]    grant_q;
	logic               complete_flag_q;
	logic [POS_W-1:0]   pend_q;
	logic [POS_W-1:0]   free_left_q;

	ffz_result_t        ffz;
	logic               in_range;
	logic [IDX_W-1:0]   idx;
	logic               used_bit;
	logic               done_bit;
	logic               produces;
	logic               out_free;
	logic               fire;

	logic [CODE_W-1:0]  code_d;
	logic [ID_W-1:0]    grant_d;
	logic               complete_d;
	logic [POS_W-1:0]   pend_d;
	map_t               in_use_d;
	map_t               complete_d_map;
	logic [FREE_W-1:0]  free_d;
	logic [POS_W-1:0]   list_pos_d;
	logic               any_found_d;
	logic               miss_seen_d;
	logic [POS_W-1:0]   miss_pos_d;

	efa_ffz u_ffz (
		.map (in_use_q),
		.res (ffz)
	);

	assign in_range = {1'b0, id_s1} < (ID_W + 1)'(ID_COUNT);
	assign idx      = IDX_W'(id_s1);
	assign used_bit = in_range && in_use_q[idx];
	assign done_bit = in_range && complete_q[idx];

	assign produces      = !(mode_s1 == MODE_WAIT && !last_s1);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && (!produces || out_free);
	assign s_axis_tready = !valid_s1 || fire;

	always_comb begin
		code_d         = RES_OK;
		grant_d        = id_s1;
		complete_d     = 1'b0;
		pend_d         = '0;
		in_use_d       = in_use_q;
		complete_d_map = complete_q;
		free_d         = free_q;
		list_pos_d     = list_pos_q;
		any_found_d    = any_found_q;
		miss_seen_d    = miss_seen_q;
		miss_pos_d     = miss_pos_q;
		case (mode_s1)
			MODE_ALLOC: begin
				if (free_q == '0 || !ffz.found) begin
					code_d  = RES_FULL;
					grant_d = '0;
				end else begin
					grant_d                   = ID_W'(ffz.index);
					in_use_d[ffz.index]       = 1'b1;
					complete_d_map[ffz.index] = 1'b0;
					free_d                    = free_q - 1'b1;
				end
			end
			MODE_RELEASE: begin
				if (!in_range) begin
					code_d = RES_INVALID;
				end else if (!used_bit) begin
					code_d = RES_COLLISION;
				end else begin
					in_use_d[idx] = 1'b0;
					free_d        = free_q + 1'b1;
				end
			end
			MODE_SET: begin
				if (!in_range || status_s1 != STATUS_COMPLETE) begin
					code_d = RES_INVALID;
				end else if (done_bit) begin
					code_d = RES_COLLISION;
				end else begin
					complete_d_map[idx] = 1'b1;
				end
			end
			MODE_GET: begin
				if (!in_range) begin
					code_d = RES_INVALID;
				end else begin
					complete_d = done_bit;
				end
			end
			MODE_WAIT: begin
				if (done_bit) begin
					any_found_d = 1'b1;
				end else if (!miss_seen_q) begin
					miss_seen_d = 1'b1;
					miss_pos_d  = list_pos_q;
				end
				if (list_pos_q != POS_MAX) begin
					list_pos_d = list_pos_q + 1'b1;
				end
				if (any_s1) begin
					code_d = any_found_d ? RES_WAIT_DONE : RES_WAIT_PENDING;
				end else if (miss_seen_d) begin
					code_d = RES_WAIT_PENDING;
					pend_d = miss_pos_d;
				end else begin
					code_d = RES_WAIT_DONE;
				end
				if (last_s1) begin
					list_pos_d  = '0;
					any_found_d = 1'b0;
					miss_seen_d = 1'b0;
					miss_pos_d  = '0;
				end
			end
			default: begin
				code_d = RES_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			mode_s1   <= s_axis_tuser[2:0];
			any_s1    <= s_axis_tuser[3];
			id_s1     <= s_axis_tdata[6:0];
			status_s1 <= s_axis_tdata[14:7];
			last_s1   <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q    <= '0;
			complete_q  <= '0;
			free_q      <= FREE_W'(ID_COUNT);
			list_pos_q  <= '0;
			any_found_q <= 1'b0;
			miss_seen_q <= 1'b0;
			miss_pos_q  <= '0;
		end else if (fire) begin
			in_use_q    <= in_use_d;
			complete_q  <= complete_d_map;
			free_q      <= free_d;
			list_pos_q  <= list_pos_d;
			any_found_q <= any_found_d;
			miss_seen_q <= miss_seen_d;
			miss_pos_q  <= miss_pos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && produces) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && produces) begin
			code_q          <= code_d;
			grant_q         <= grant_d;
			complete_flag_q <= complete_d;
			pend_q          <= pend_d;
			free_left_q     <= POS_W'(free_d);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = code_q;
	assign m_axis_tdata  = {free_left_q, pend_q, complete_flag_q, grant_q};

	// The free count always matches the number of clear bits in the in-use map.
	a_free_count: assert property (@(posedge clk) disable iff (!arst_n)
		free_q == FREE_W'(ID_COUNT - $countones(in_use_q)))
		else $error("free count disagrees with the in-use map");

	// The list accumulators are cleared after the last element of a list.
	a_list_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && mode_s1 == MODE_WAIT && last_s1 |=>
		list_pos_q == '0 && !any_found_q && !miss_seen_q)
		else $error("wait-list state not cleared after the last element");

	// A successful allocation leaves the granted identifier marked in use.
	a_alloc_mark: assert property (@(posedge clk) disable iff (!arst_n)
		fire && mode_s1 == MODE_ALLOC && code_d == RES_OK |=>
		in_use_q[$past(ffz.index)] && !complete_q[$past(ffz.index)])
		else $error("allocated identifier not marked in use");

	// A pending position is reported only with a pending wait result.
	a_pend_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && pend_q != '0 |-> code_q == RES_WAIT_PENDING)
		else $error("pending position reported with another result code");

endmodule
